FILE: design/assert_macros.svh
// Assertion macros used by the cache top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define KVC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define KVC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define KVC_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/kvc_pkg.sv
// Shared types and constants of the key/value cache.
`timescale 1ns / 1ps
package kvc_pkg;

  localparam int KVC_MAX_ENTRIES = 64;
  localparam int KVC_KEY_W       = 64;
  localparam int KVC_VAL_W       = 64;
  localparam int KVC_CAP_W       = 7;
  localparam int KVC_COUNT_W     = 7;
  localparam int KVC_CMD_W       = 2;
  localparam int KVC_CFG_IDX_W   = 1;
  localparam int KVC_CFG_DATA_W  = 7;

  typedef enum logic [KVC_CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_t;

  typedef enum logic {
    MODE_LRU  = 1'b0,
    MODE_FIFO = 1'b1
  } mode_t;

  typedef enum logic [KVC_CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_MODE     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic                 tok;
    logic                 found;
    logic [KVC_VAL_W-1:0] hit_value;
    logic                 inv_seen;
    logic                 cand_seen;
    logic                 oldest_seen;
    logic [KVC_KEY_W-1:0] oldest_key;
  } srch_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic                 en;
    logic                 newest;
    logic                 write_hit;
    logic                 insert;
    logic                 evict;
    logic [KVC_KEY_W-1:0] key;
    logic [KVC_VAL_W-1:0] value;
  } upd_t;

endpackage

FILE: design/kvc_cell.sv
// One cache entry with its search stage and its update logic.
`timescale 1ns / 1ps
module kvc_cell #(
  parameter int RANK_W = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [kvc_pkg::KVC_KEY_W-1:0]  key_i,
  input  logic [RANK_W-1:0]              oldest_rank_i,
  input  kvc_pkg::srch_t                 srch_i,
  input  logic [RANK_W-1:0]              srch_rank_i,
  output kvc_pkg::srch_t                 srch_o,
  output logic [RANK_W-1:0]              srch_rank_o,
  input  kvc_pkg::upd_t                  upd_i,
  input  logic [RANK_W-1:0]              promote_rank_i
);
  import kvc_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [KVC_KEY_W-1:0] key_r, key_nxt;
  logic [KVC_VAL_W-1:0] value_r, value_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;

  logic                 match_r, inv_mark_r, cand_mark_r, oldest_r;
  logic                 tok_r;
  srch_t                srch_data_r, srch_data_nxt;
  logic [RANK_W-1:0]    hit_rank_r, hit_rank_nxt;

  logic                 match;
  logic                 is_oldest;
  logic                 target;

  assign match     = valid_r && (key_r == key_i);
  assign is_oldest = valid_r && (rank_r == oldest_rank_i);

  always_comb begin
    srch_data_nxt = srch_i;
    hit_rank_nxt  = srch_rank_i;
    if (match && !srch_i.found) begin
      srch_data_nxt.found     = 1'b1;
      srch_data_nxt.hit_value = value_r;
      hit_rank_nxt            = rank_r;
    end
    if (!valid_r) begin
      srch_data_nxt.inv_seen = 1'b1;
    end
    if (!valid_r || is_oldest) begin
      srch_data_nxt.cand_seen = 1'b1;
    end
    if (is_oldest && !srch_i.oldest_seen) begin
      srch_data_nxt.oldest_seen = 1'b1;
      srch_data_nxt.oldest_key  = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= srch_i.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (srch_i.tok) begin
      srch_data_r <= srch_data_nxt;
      hit_rank_r  <= hit_rank_nxt;
      match_r     <= match;
      inv_mark_r  <= !valid_r && !srch_i.inv_seen;
      cand_mark_r <= (!valid_r || is_oldest) && !srch_i.cand_seen;
      oldest_r    <= is_oldest;
    end
  end

  always_comb begin
    srch_o      = srch_data_r;
    srch_o.tok  = tok_r;
    srch_rank_o = hit_rank_r;
  end

  assign target = upd_i.evict ? cand_mark_r : inv_mark_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    rank_nxt  = rank_r;
    if (upd_i.en) begin
      if (upd_i.newest) begin
        if (valid_r && (rank_r < promote_rank_i)) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
        if (match_r) begin
          rank_nxt = '0;
        end
      end
      if (upd_i.write_hit && match_r) begin
        value_nxt = upd_i.value;
      end
      if (upd_i.insert) begin
        if (upd_i.evict && oldest_r) begin
          valid_nxt = 1'b0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
        if (target) begin
          valid_nxt = 1'b1;
          key_nxt   = upd_i.key;
          value_nxt = upd_i.value;
          rank_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    rank_r  <= rank_nxt;
  end

endmodule

FILE: design/key_value_cache_lru_fifo_top.sv
// Top level of the key/value cache: control, configuration and the row of entry cells.
// One item at a time: the search token walks the row of cells, one cell per cycle, then
// the update state writes the cells once the output register is free.
// The next item is taken while the previous result still waits for its transfer.
// Reset empties the cache, sets the capacity to 64 and selects LRU replacement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module key_value_cache_lru_fifo_top #(
  parameter int MAX_ENTRIES = kvc_pkg::KVC_MAX_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kvc_pkg::KVC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [kvc_pkg::KVC_CFG_DATA_W-1:0] cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kvc_pkg::KVC_CMD_W-1:0]      in_command,
  input  logic [kvc_pkg::KVC_KEY_W-1:0]      in_key,
  input  logic [kvc_pkg::KVC_VAL_W-1:0]      in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [kvc_pkg::KVC_VAL_W-1:0]      out_hit_value,
  output logic                               out_evicted,
  output logic [kvc_pkg::KVC_KEY_W-1:0]      out_evicted_key,
  output logic [kvc_pkg::KVC_COUNT_W-1:0]    out_entry_count
);
  import kvc_pkg::*;

  localparam int RANK_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W  = (CNT_W > KVC_CAP_W) ? CNT_W : KVC_CAP_W;

  state_t                 state_r, state_nxt;
  logic                   start_r;
  logic [KVC_CMD_W-1:0]   cmd_r;
  logic [KVC_KEY_W-1:0]   key_r;
  logic [KVC_VAL_W-1:0]   val_r;
  logic [KVC_CAP_W-1:0]   cap_r;
  mode_t                  mode_r;
  logic [CNT_W-1:0]       filled_r, filled_nxt;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [KVC_VAL_W-1:0]   out_hit_value_r;
  logic                   out_evicted_r;
  logic [KVC_KEY_W-1:0]   out_evicted_key_r;
  logic [KVC_COUNT_W-1:0] out_entry_count_r;

  srch_t                  link [MAX_ENTRIES+1];
  logic [RANK_W-1:0]      link_rank [MAX_ENTRIES+1];
  srch_t                  fin;
  upd_t                   upd;
  logic [RANK_W-1:0]      oldest_rank;

  logic                   in_fire;
  logic                   out_free;
  logic                   upd_en;
  logic [EXT_W-1:0]       eff_cap;
  logic                   is_touch, is_insert;
  logic                   evict;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign fin      = link[MAX_ENTRIES];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (fin.tok) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    upd_en   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEARCH: upd_en   = 1'b0;
      ST_UPDATE: upd_en   = out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= KVC_CAP_W'(64);
      mode_r <= MODE_LRU;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r  <= cfg_wdata[KVC_CAP_W-1:0];
        CFG_MODE:     mode_r <= mode_t'(cfg_wdata[0]);
        default:      cap_r  <= cap_r;
      endcase
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EXT_W'(1);
    end else if (EXT_W'(cap_r) > EXT_W'(MAX_ENTRIES)) begin
      eff_cap = EXT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = EXT_W'(cap_r);
    end
  end

  assign oldest_rank = RANK_W'(filled_r - CNT_W'(1));
  assign is_touch    = (cmd_r == CMD_TOUCH);
  assign is_insert   = (cmd_r == CMD_INSERT);
  assign evict       = !fin.found && is_insert && (EXT_W'(filled_r) >= eff_cap);

  always_comb begin
    upd           = '0;
    upd.en        = upd_en;
    upd.newest    = fin.found && (mode_r == MODE_LRU) && (is_touch || is_insert);
    upd.write_hit = fin.found && is_insert;
    upd.insert    = !fin.found && is_insert;
    upd.evict     = evict;
    upd.key       = key_r;
    upd.value     = val_r;
  end

  always_comb begin
    filled_nxt = filled_r;
    if (upd.insert && !evict) begin
      filled_nxt = filled_r + CNT_W'(1);
    end
  end

  always_comb begin
    link[0]      = '0;
    link[0].tok  = start_r;
    link_rank[0] = '0;
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    kvc_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .key_i          (key_r),
      .oldest_rank_i  (oldest_rank),
      .srch_i         (link[g]),
      .srch_rank_i    (link_rank[g]),
      .srch_o         (link[g+1]),
      .srch_rank_o    (link_rank[g+1]),
      .upd_i          (upd),
      .promote_rank_i (link_rank[MAX_ENTRIES])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd_en) begin
        filled_r    <= filled_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_hit_r         <= fin.found;
      out_hit_value_r   <= fin.found ? fin.hit_value : '0;
      out_evicted_r     <= evict;
      out_evicted_key_r <= evict ? fin.oldest_key : '0;
      out_entry_count_r <= KVC_COUNT_W'(filled_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_value   = out_hit_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;
  assign out_entry_count = out_entry_count_r;

  `KVC_ASSERT(a_fill_bound, filled_r <= CNT_W'(MAX_ENTRIES), "fill count exceeds the cache size")
  `KVC_IMPLY(a_evict_victim, upd_en && evict, fin.oldest_seen, "eviction found no oldest entry")
  `KVC_NEXT(a_accept_starts, in_fire, start_r && (state_r == ST_SEARCH), "search did not start")
  `KVC_IMPLY(a_idle_quiet, state_r == ST_IDLE, !fin.tok && !start_r, "search token seen while idle")

endmodule

FILE: tb/sv/key_value_cache_lru_fifo_top_test.sv
// Self-checking testbench for the LRU/FIFO key/value cache top level.
`timescale 1ns / 1ps
module key_value_cache_lru_fifo_top_test;
  import kvc_pkg::*;

  localparam int ENTRIES = KVC_MAX_ENTRIES;
  localparam logic [KVC_CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 1500;
  localparam int KEY_POOL = 100;
  localparam logic [KVC_KEY_W-1:0] KEY_FIVES = 64'h5555_5555_5555_5555;
  localparam logic [KVC_KEY_W-1:0] KEY_TENS = 64'haaaa_aaaa_aaaa_aaaa;

  typedef struct packed {
    logic [KVC_CMD_W-1:0] cmd;
    logic [KVC_KEY_W-1:0] key;
    logic [KVC_VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic                   hit;
    logic [KVC_VAL_W-1:0]   hit_value;
    logic                   evicted;
    logic [KVC_KEY_W-1:0]   evicted_key;
    logic [KVC_COUNT_W-1:0] entry_count;
  } response_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [KVC_CFG_IDX_W-1:0]    cfg_index = '0;
  logic [KVC_CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [KVC_CMD_W-1:0]        in_command = '0;
  logic [KVC_KEY_W-1:0]        in_key = '0;
  logic [KVC_VAL_W-1:0]        in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_hit;
  logic [KVC_VAL_W-1:0]        out_hit_value;
  logic                        out_evicted;
  logic [KVC_KEY_W-1:0]        out_evicted_key;
  logic [KVC_COUNT_W-1:0]      out_entry_count;

  // Shadow copy of the cache contents and its settings.
  logic                 c_valid [ENTRIES];
  logic [KVC_KEY_W-1:0] c_key   [ENTRIES];
  logic [KVC_VAL_W-1:0] c_value [ENTRIES];
  int                   c_rank  [ENTRIES];
  int                   c_fill;
  logic [KVC_CAP_W-1:0] c_cap;
  mode_t                c_mode;

  request_t  request_q [$];
  response_t awaited [$];
  request_t  next_req;
  response_t want;
  logic [KVC_KEY_W-1:0] key_pool [KEY_POOL];

  int send_wait = 0;
  int send_max = 0;
  int recv_wait = 0;
  int recv_max = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int phase_no = -1;
  int fail_count = 0;
  int cfg_writes = 0;
  int hit_seen = 0;
  int evict_seen = 0;
  int cmd_seen [4] = '{0, 0, 0, 0};

  int    phase_cap   [PHASES] = '{6, 12, 1, 0, 40, 64, 127, 64};
  mode_t phase_mode  [PHASES] = '{MODE_LRU, MODE_FIFO, MODE_LRU, MODE_FIFO,
                                  MODE_LRU, MODE_FIFO, MODE_LRU, MODE_LRU};
  int    phase_items [PHASES] = '{150, 200, 120, 100, 250, 250, 200, 260};
  int    phase_send  [PHASES] = '{8, 0, 8, 3, 0, 0, 8, 8};
  int    phase_recv  [PHASES] = '{8, 8, 0, 8, 8, 0, 3, 8};

  key_value_cache_lru_fifo_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_value   (out_hit_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_entry_count (out_entry_count)
  );

  always #5 clk = ~clk;

  function automatic void promote_entry(int slot);
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_valid[i] && c_rank[i] < c_rank[slot]) begin
        c_rank[i]++;
      end
    end
    c_rank[slot] = 0;
  endfunction

  function automatic response_t cache_access(logic [KVC_CMD_W-1:0] cmd,
                                             logic [KVC_KEY_W-1:0] key,
                                             logic [KVC_VAL_W-1:0] value);
    response_t resp;
    bit found;
    bit any;
    int slot;
    int victim;
    int free_slot;
    int limit;
    resp = '0;
    found = 1'b0;
    any = 1'b0;
    slot = 0;
    victim = 0;
    free_slot = ENTRIES;
    limit = (c_cap == 0) ? 1 : (c_cap > ENTRIES) ? ENTRIES : int'(c_cap);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && c_valid[i] && c_key[i] == key) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      resp.hit = 1'b1;
      resp.hit_value = c_value[slot];
    end
    if (cmd == CMD_TOUCH) begin
      if (found && c_mode == MODE_LRU) begin
        promote_entry(slot);
      end
    end else if (cmd == CMD_INSERT) begin
      if (found) begin
        c_value[slot] = value;
        if (c_mode == MODE_LRU) begin
          promote_entry(slot);
        end
      end else begin
        if (c_fill >= limit && c_fill > 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (c_valid[i] && (!any || c_rank[i] > c_rank[victim])) begin
              any = 1'b1;
              victim = i;
            end
          end
          if (any) begin
            resp.evicted = 1'b1;
            resp.evicted_key = c_key[victim];
            c_valid[victim] = 1'b0;
            c_fill--;
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_slot == ENTRIES && !c_valid[i]) begin
            free_slot = i;
          end
        end
        if (free_slot < ENTRIES) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (c_valid[i]) begin
              c_rank[i]++;
            end
          end
          c_valid[free_slot] = 1'b1;
          c_key[free_slot] = key;
          c_value[free_slot] = value;
          c_rank[free_slot] = 0;
          c_fill++;
        end
      end
    end
    resp.entry_count = KVC_COUNT_W'(c_fill);
    return resp;
  endfunction

  task automatic write_register(cfg_idx_t idx, logic [KVC_CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) begin
      c_cap = data;
    end else begin
      c_mode = mode_t'(data[0]);
    end
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic queue_request(logic [KVC_CMD_W-1:0] cmd, logic [KVC_KEY_W-1:0] key,
                               logic [KVC_VAL_W-1:0] value);
    request_t item;
    item.cmd = cmd;
    item.key = key;
    item.value = value;
    request_q.push_back(item);
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (request_q.size() != 0 || in_valid || awaited.size() != 0);
  endtask

  // Sender: every accepted transfer is run through the shadow cache right away.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        awaited.push_back(cache_access(in_command, in_key, in_value));
        cmd_seen[in_command]++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          in_valid <= 1'b1;
          in_command <= next_req.cmd;
          in_key <= next_req.key;
          in_value <= next_req.value;
          send_wait = $urandom_range(0, send_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (phase_no == HOLD_PHASE && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result transfer against the oldest predicted response.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result transfer with no response predicted");
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            fail_count++;
          end
          if (out_hit_value !== want.hit_value) begin
            $error("hit_value: expected %h, got %h", want.hit_value, out_hit_value);
            fail_count++;
          end
          if (out_evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, out_evicted);
            fail_count++;
          end
          if (out_evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h, got %h", want.evicted_key, out_evicted_key);
            fail_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
            fail_count++;
          end
          hit_seen += want.hit;
          evict_seen += want.evicted;
        end
        recv_wait = $urandom_range(0, recv_max);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int span;
    int pick;
    logic [KVC_CMD_W-1:0] cmd;
    logic [KVC_KEY_W-1:0] key;
    for (int i = 0; i < ENTRIES; i++) begin
      c_valid[i] = 1'b0;
      c_key[i] = '0;
      c_value[i] = '0;
      c_rank[i] = 0;
    end
    c_fill = 0;
    c_cap = 7'd64;
    c_mode = MODE_LRU;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_max = 2;
    recv_max = 2;

    write_register(CFG_CAPACITY, 7'd3);
    write_register(CFG_MODE, 7'(MODE_LRU));
    queue_request(CMD_LOOKUP, '0, '1);
    queue_request(CMD_INSERT, '0, '1);
    queue_request(CMD_INSERT, '1, '0);
    queue_request(CMD_INSERT, KEY_FIVES, KEY_TENS);
    queue_request(CMD_LOOKUP, '1, '0);
    queue_request(CMD_TOUCH, '0, '0);
    queue_request(CMD_INSERT, KEY_TENS, 64'd1);
    queue_request(CMD_INSERT, '0, 64'h1234);
    queue_request(CMD_UNUSED, KEY_FIVES, '1);
    queue_request(CMD_TOUCH, 64'd7, '0);
    drain();

    // FIFO order must ignore touches and updates of present keys.
    write_register(CFG_MODE, 7'(MODE_FIFO));
    queue_request(CMD_TOUCH, KEY_FIVES, '0);
    queue_request(CMD_INSERT, 64'd1, 64'd2);
    queue_request(CMD_INSERT, KEY_TENS, 64'd3);
    queue_request(CMD_INSERT, 64'd2, 64'd4);
    drain();

    // A zero capacity behaves as one, with the fill held above it.
    write_register(CFG_CAPACITY, 7'd0);
    queue_request(CMD_INSERT, 64'd3, 64'd5);
    queue_request(CMD_INSERT, 64'd4, 64'd6);
    queue_request(CMD_LOOKUP, 64'd4, '0);
    drain();

    write_register(CFG_CAPACITY, 7'd127);
    write_register(CFG_MODE, 7'(MODE_LRU));
    queue_request(CMD_INSERT, 64'd5, 64'd7);
    queue_request(CMD_TOUCH, 64'd3, '0);
    queue_request(CMD_LOOKUP, '1, '0);
    drain();

    // The fill never shrinks, even in the phases that lower the capacity again.
    for (int p = 0; p < PHASES; p++) begin
      phase_no = p;
      send_max = phase_send[p];
      recv_max = phase_recv[p];
      write_register(CFG_CAPACITY, 7'(phase_cap[p]));
      write_register(CFG_MODE, 7'(phase_mode[p]));
      span = phase_cap[p] * 3 / 2 + 4;
      if (span > KEY_POOL) begin
        span = KEY_POOL;
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        pick = $urandom_range(0, 99);
        cmd = (pick < 25) ? CMD_LOOKUP : (pick < 50) ? CMD_TOUCH :
              (pick < 90) ? CMD_INSERT : CMD_UNUSED;
        if ($urandom_range(0, 99) < 85) begin
          key = key_pool[$urandom_range(0, span - 1)];
        end else begin
          key = {$urandom, $urandom};
        end
        queue_request(cmd, key, {$urandom, $urandom});
      end
      drain();
    end

    repeat (2 * ENTRIES) @(posedge clk);
    $display("Ran %0d lookups, %0d touches, %0d inserts and %0d unused-code requests",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("over %0d register writes; %0d hits and %0d evictions were checked.",
             cfg_writes, hit_seen, evict_seen);
    if (fail_count == 0) begin
      $display("PASS key_value_cache_lru_fifo_top");
    end else begin
      $display("FAIL key_value_cache_lru_fifo_top");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL key_value_cache_lru_fifo_top");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/kvc_pkg.sv
design/kvc_cell.sv
design/key_value_cache_lru_fifo_top.sv
tb/sv/key_value_cache_lru_fifo_top_test.sv
